// ===== hw/rtl/lbcc_pkg.sv =====
// Shared types and constants for the LED blink code controller.
package lbcc_pkg;

  // Command codes carried in the input kind field.
  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_ON     = 3'd1,
    FUNC_OFF    = 3'd2,
    FUNC_TOGGLE = 3'd3,
    FUNC_BLINK  = 3'd4
  } func_t;

  // Field widths fixed by the command format.
  localparam int FuncW    = 3;
  localparam int LedW     = 2;
  localparam int CountW   = 8;
  localparam int NowW     = 32;
  localparam int HalfW    = 16;

  // Per-LED blink state widths.
  localparam int TargetW  = 4;
  localparam int PhaseW   = 5;

  // Packed stream widths.
  localparam int InDataW  = 48;
  localparam int OutDataW = 8;
  localparam int OutUserW = 1;

  // Reset value of the half period register.
  localparam logic [HalfW-1:0] HalfPeriodReset = 16'd150;

endpackage

// ===== hw/rtl/led_blink_code_controller_unit.sv =====
// LED blink code controller: command decode, blink sequencing and output buffering.
//
//   channel | direction | tdata / data                        | tuser
//   s_*     | in        | led, blink_count, now_ms             | func
//   m_*     | out       | led_ready_on, led_data_on, led_error | step_taken
//   cfg_*   | in        | half_period_ms                       | -
//
// The LED state updates at the accepting edge, and the result is registered at that
// edge into the output register, or into the skid register while a result is stalled.
// A skid register behind the output register lets one more request in while a
// result is stalled; s_tready drops only when both hold a result.
// Synchronous reset turns all LEDs off, stops blinking and sets the half period
// to 150 ms. The config port is always ready.
module led_blink_code_controller_unit
  import lbcc_pkg::*;
#(
  parameter int NUM_LEDS   = 3,
  parameter int MAX_BLINKS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [1:0] led, [9:2] blink_count, [41:10] now_ms, [47:42] zero
  input  logic [InDataW-1:0]  s_tdata,
  // [2:0] func
  input  logic [FuncW-1:0]    s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] led_ready_on, [1] led_data_on, [2] led_error_on, [7:3] zero
  output logic [OutDataW-1:0] m_tdata,
  // [0] step_taken
  output logic [OutUserW-1:0] m_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HalfW-1:0]    cfg_data
);

  localparam int PadLeds = (NUM_LEDS > 3) ? NUM_LEDS : 3;
  localparam logic [CountW-1:0] MaxBlinks = CountW'(MAX_BLINKS);

  // Unpack the request.
  func_t                func;
  logic [LedW-1:0]      led;
  logic [CountW-1:0]    blink_count;
  logic [TIME_BITS-1:0] now_t;

  assign func        = func_t'(s_tuser);
  assign led         = s_tdata[LedW-1:0];
  assign blink_count = s_tdata[LedW+CountW-1:LedW];
  assign now_t       = TIME_BITS'(s_tdata[LedW+CountW+NowW-1:LedW+CountW]);

  // State.
  logic [HalfW-1:0]     half_period;
  logic [TIME_BITS-1:0] last_step_time;
  logic [TIME_BITS-1:0] last_step_time_next;
  logic [NUM_LEDS-1:0]  pin;
  logic [NUM_LEDS-1:0]  pin_next;
  logic [TargetW-1:0]   target      [NUM_LEDS];
  logic [TargetW-1:0]   target_next [NUM_LEDS];
  logic [PhaseW-1:0]    phase       [NUM_LEDS];
  logic [PhaseW-1:0]    phase_next  [NUM_LEDS];
  logic                 stepped;

  // Output buffering.
  logic                 skid_valid;
  logic [OutDataW-1:0]  skid_data;
  logic [OutUserW-1:0]  skid_user;
  logic                 in_fire;
  logic                 out_fire;

  assign s_tready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;

  // Tick qualification: elapsed time wraps modulo the time width.
  logic [TIME_BITS-1:0] elapsed;
  logic                 tick_ok;

  assign elapsed = now_t - last_step_time;
  assign tick_ok = (func == FUNC_TICK) && (elapsed >= TIME_BITS'(half_period));

  // Next LED state for the current request.
  always_comb begin
    logic [CountW-1:0]  tgt;
    logic [TargetW-1:0] tgt_c;
    logic               hit;
    last_step_time_next = last_step_time;
    stepped             = 1'b0;
    pin_next            = pin;
    for (int i = 0; i < NUM_LEDS; i++) begin
      target_next[i] = target[i];
      phase_next[i]  = phase[i];
    end
    if (tick_ok) begin
      last_step_time_next = now_t;
      stepped             = 1'b1;
    end
    for (int i = 0; i < NUM_LEDS; i++) begin
      hit   = (int'(led) == i);
      tgt   = (blink_count > CountW'(target[i])) ? blink_count : CountW'(target[i]);
      if (tgt == '0) begin
        tgt = CountW'(1);
      end
      if (tgt > MaxBlinks) begin
        tgt = MaxBlinks;
      end
      tgt_c = tgt[TargetW-1:0];
      case (func)
        FUNC_TICK: begin
          // One blink step for every LED that runs a code.
          if (tick_ok && (target[i] != '0)) begin
            if (phase[i] == {target[i], 1'b0}) begin
              phase_next[i] = '0;
              pin_next[i]   = 1'b1;
            end else if (phase[i] < PhaseW'(target[i])) begin
              pin_next[i] = !pin[i];
              if (pin[i]) begin
                phase_next[i] = phase[i] + PhaseW'(1);
              end
            end else begin
              phase_next[i] = phase[i] + PhaseW'(1);
            end
          end
        end
        FUNC_ON: begin
          if (hit) begin
            target_next[i] = '0;
            pin_next[i]    = 1'b1;
          end
        end
        FUNC_OFF: begin
          if (hit) begin
            target_next[i] = '0;
            pin_next[i]    = 1'b0;
          end
        end
        FUNC_TOGGLE: begin
          // A blinking LED is stopped and turned off instead of toggled.
          if (hit) begin
            if (target[i] == '0) begin
              pin_next[i] = !pin[i];
            end else begin
              target_next[i] = '0;
              pin_next[i]    = 1'b0;
            end
          end
        end
        FUNC_BLINK: begin
          // Raise the target only; the next step turns the LED on.
          if (hit) begin
            target_next[i] = tgt_c;
            phase_next[i]  = {tgt_c, 1'b0};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for this request; LEDs beyond the count read as off.
  logic [PadLeds-1:0]  lvl_pad;
  logic [OutDataW-1:0] res_data;
  logic [OutUserW-1:0] res_user;

  assign lvl_pad  = PadLeds'(pin_next);
  assign res_data = OutDataW'(lvl_pad[2:0]);
  assign res_user = OutUserW'(stepped);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  // LED state update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_step_time <= '0;
      pin            <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        target[i] <= '0;
        phase[i]  <= '0;
      end
    end else if (in_fire) begin
      last_step_time <= last_step_time_next;
      pin            <= pin_next;
      for (int i = 0; i < NUM_LEDS; i++) begin
        target[i] <= target_next[i];
        phase[i]  <= phase_next[i];
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!m_tvalid || out_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end
    end else if (in_fire) begin
      if (!m_tvalid || out_fire) begin
        m_tdata <= res_data;
        m_tuser <= res_user;
      end else begin
        skid_data <= res_data;
        skid_user <= res_user;
      end
    end
  end

endmodule
